>>> hdl/tle_pkg.sv
// ---------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: token kinds,
// key codes, request selectors and the job descriptor handed to the sequencer.
// ---------------------------------------------------------------------------
package tle_pkg;

    localparam int TLE_LINE_DEPTH = 16;
    localparam int LEN_W = 5;
    localparam int KIND_W = 3;

    // token kinds
    localparam logic [KIND_W-1:0] TOK_LIT   = 3'd0;
    localparam logic [KIND_W-1:0] TOK_LEFT  = 3'd1;
    localparam logic [KIND_W-1:0] TOK_RIGHT = 3'd2;
    localparam logic [KIND_W-1:0] TOK_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] TOK_ERASE = 3'd4;
    localparam logic [KIND_W-1:0] TOK_READ  = 3'd5;

    // request selectors
    localparam logic [1:0] FUNC_KEY  = 2'd0;
    localparam logic [1:0] FUNC_NEW  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // key bytes
    localparam logic [7:0] KEY_BS      = 8'h08;
    localparam logic [7:0] KEY_LF      = 8'h0a;
    localparam logic [7:0] KEY_FF      = 8'h0c;
    localparam logic [7:0] KEY_ESC     = 8'd27;
    localparam logic [7:0] KEY_BRACKET = 8'd91;
    localparam logic [7:0] KEY_RIGHT   = 8'd67;
    localparam logic [7:0] KEY_LEFT    = 8'd68;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;

    // work for one request, in emission order:
    // head token, tail shift, literal run, trailing space, cursor run, final byte
    typedef struct packed {
        logic              head_en;
        logic [KIND_W-1:0] head_kind;
        logic              shift_en;
        logic [LEN_W-1:0]  shift_hi;
        logic [LEN_W-1:0]  shift_lo;
        logic [7:0]        ins_byte;
        logic [LEN_W-1:0]  lit_lo;
        logic [LEN_W-1:0]  lit_cnt;
        logic [KIND_W-1:0] lit_kind;
        logic              lit_wb;
        logic              read_zero;
        logic              tail_en;
        logic [KIND_W-1:0] move_kind;
        logic [LEN_W-1:0]  move_cnt;
        logic              final_en;
        logic [7:0]        final_byte;
    } tle_job_t;

endpackage

>>> hdl/tle_line_mem.sv
// ---------------------------------------------------------------------------
// tle_line_mem
// Line store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tle_line_mem import tle_pkg::*; #(
    parameter int LINE_DEPTH = TLE_LINE_DEPTH,
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [LINE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/tle_seq.sv
// ---------------------------------------------------------------------------
// tle_seq
// Token sequencer: walks the line store one entry per step, shifting the
// tail and emitting echo tokens into the output register.
// ---------------------------------------------------------------------------
module tle_seq import tle_pkg::*; #(
    parameter int LINE_DEPTH = TLE_LINE_DEPTH,
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  tle_job_t          job,
    input  logic              done_in,
    input  logic [LEN_W-1:0]  len_in,
    output logic              busy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_token_kind,
    output logic [7:0]        m_token_byte,
    output logic              m_last,
    output logic              m_line_done,
    output logic [LEN_W-1:0]  m_line_length,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [7:0]        mem_rdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HEAD   = 4'd1;
    localparam logic [3:0] S_SH_RD  = 4'd2;
    localparam logic [3:0] S_SH_WR  = 4'd3;
    localparam logic [3:0] S_LIT_RD = 4'd4;
    localparam logic [3:0] S_LIT_EM = 4'd5;
    localparam logic [3:0] S_TAIL   = 4'd6;
    localparam logic [3:0] S_MOVE   = 4'd7;
    localparam logic [3:0] S_FINAL  = 4'd8;

    logic [3:0]        state_reg, state_next;
    tle_job_t          job_reg, job_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  mv_reg, mv_next;
    logic              m_valid_reg;

    logic              out_free;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic [7:0]        emit_byte;
    logic              emit_last;
    logic [LEN_W-1:0]  idx_dec;
    logic              rest_mv;

    assign out_free = !m_valid_reg || m_ready;
    assign idx_dec  = idx_reg - 5'd1;
    assign rest_mv  = (mv_reg != '0) || job_reg.final_en;
    assign busy     = (state_reg != S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg;
        emit       = 1'b0;
        emit_kind  = TOK_LIT;
        emit_byte  = '0;
        emit_last  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    job_next   = job;
                    cnt_next   = job.lit_cnt;
                    mv_next    = job.move_cnt;
                    idx_next   = job.shift_en ? job.shift_hi : job.lit_lo;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                if (!job_reg.head_en) begin
                    state_next = S_SH_RD;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = job_reg.head_kind;
                    emit_last  = (cnt_reg == '0) && !job_reg.tail_en && !rest_mv;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD: begin
                mem_raddr = idx_dec[AW-1:0];
                if (!job_reg.shift_en) begin
                    state_next = S_LIT_RD;
                end else if (idx_reg == job_reg.shift_lo) begin
                    mem_we     = 1'b1;
                    mem_wdata  = job_reg.ins_byte;
                    idx_next   = job_reg.lit_lo;
                    state_next = S_LIT_RD;
                end else begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_raddr  = idx_dec[AW-1:0];
                mem_we     = 1'b1;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end
            S_LIT_RD: begin
                state_next = (cnt_reg == '0) ? S_TAIL : S_LIT_EM;
            end
            S_LIT_EM: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = job_reg.lit_kind;
                    emit_byte = job_reg.read_zero ? 8'd0 : mem_rdata;
                    emit_last = (cnt_reg == 5'd1) && !job_reg.tail_en && !rest_mv;
                    if (job_reg.lit_wb) begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_dec[AW-1:0];
                    end
                    idx_next   = idx_reg + 5'd1;
                    cnt_next   = cnt_reg - 5'd1;
                    state_next = S_LIT_RD;
                end
            end
            S_TAIL: begin
                if (!job_reg.tail_en) begin
                    state_next = S_MOVE;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = BYTE_SPACE;
                    emit_last  = !rest_mv;
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                if (mv_reg == '0) begin
                    state_next = S_FINAL;
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = job_reg.move_kind;
                    emit_last = (mv_reg == 5'd1) && !job_reg.final_en;
                    mv_next   = mv_reg - 5'd1;
                end
            end
            S_FINAL: begin
                if (!job_reg.final_en) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = job_reg.final_byte;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        mv_reg  <= mv_next;
        if (emit) begin
            m_token_kind  <= emit_kind;
            m_token_byte  <= emit_byte;
            m_last        <= emit_last;
            m_line_done   <= done_in;
            m_line_length <= len_in;
        end
    end

endmodule

>>> hdl/terminal_line_editor.sv
// ---------------------------------------------------------------------------
// terminal_line_editor
// Line editor driven by key bytes; echoes every edit as terminal tokens.
// ---------------------------------------------------------------------------
// usage:
//   s_* channel takes one request: a key byte, a new-line start or a read
//   of a stored character. m_* channel returns the tokens the request
//   causes, m_last marking the final one. silent requests return nothing.
//   cfg_* channel writes max_length; write it only while the block is idle.
// timing:
//   the line store is walked one entry per step by a single sequencer with
//   one write port and one read port: each character read is a read step
//   and an emit step, and each tail shift entry a read step and a write step.
//   a silent request leaves s_ready high; a request with tokens holds s_ready
//   low for its whole run plus receiver stalls, longest for an insert at the
//   start of a nearly full line. an insert emits its first token only after
//   the tail shift. s_ready stays low until the last token sits in the output register.
// reset:
//   synchronous active-low aresetn; line empty and finished, no escape
//   pending, max_length 16. the store content is undefined until written.
// stalls:
//   a low m_ready holds the token and stalls the sequencer at its next token; nothing drops.
// ---------------------------------------------------------------------------
module terminal_line_editor import tle_pkg::*; #(
    parameter int LINE_DEPTH = TLE_LINE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_key,
    input  logic [3:0]        s_read_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_token_kind,
    output logic [7:0]        m_token_byte,
    output logic              m_last,
    output logic              m_line_done,
    output logic [LEN_W-1:0]  m_line_length,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data
);

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

    // escape sequence phases
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] cursor_reg, cursor_next;
    logic [1:0]       escape_reg, escape_next;
    logic             finished_reg, finished_next;

    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] ridx_ext;
    logic             accept;
    logic             start;
    logic             busy;
    tle_job_t         job;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !busy;
    assign cfg_ready = 1'b1;
    // limits above the store depth act as the depth
    assign limit     = (max_len_reg > DEPTH_L) ? DEPTH_L : max_len_reg;
    assign rem       = length_reg - cursor_reg;
    assign ridx_ext  = {1'b0, s_read_index};

    // request decode: editing state updates at once, tokens follow from the job
    always_comb begin
        length_next   = length_reg;
        cursor_next   = cursor_reg;
        escape_next   = escape_reg;
        finished_next = finished_reg;
        start         = 1'b0;
        job           = '0;
        job.lit_kind  = TOK_LIT;
        job.move_kind = TOK_LEFT;
        if (accept) begin
            case (s_func)
                FUNC_KEY: begin
                    if (!finished_reg) begin
                        if (length_reg >= limit) begin
                            // full line: key only closes it
                            finished_next = 1'b1;
                        end else begin
                            if (escape_reg == ESC_SEEN) begin
                                escape_next = (s_key == KEY_BRACKET) ? ESC_CSI : ESC_NONE;
                            end else if (escape_reg == ESC_CSI) begin
                                escape_next = ESC_NONE;
                                if (s_key == KEY_LEFT && cursor_reg != '0) begin
                                    start         = 1'b1;
                                    job.move_kind = TOK_LEFT;
                                    job.move_cnt  = 5'd1;
                                    cursor_next   = cursor_reg - 5'd1;
                                end else if (s_key == KEY_RIGHT && cursor_reg < length_reg) begin
                                    start         = 1'b1;
                                    job.move_kind = TOK_RIGHT;
                                    job.move_cnt  = 5'd1;
                                    cursor_next   = cursor_reg + 5'd1;
                                end
                            end else begin
                                escape_next = ESC_NONE;
                                if (s_key == KEY_BS) begin
                                    if (length_reg != '0 && cursor_reg != '0) begin
                                        start         = 1'b1;
                                        job.head_en   = 1'b1;
                                        job.head_kind = TOK_ERASE;
                                        if (cursor_reg != length_reg) begin
                                            // pull the tail left while echoing it
                                            job.lit_lo   = cursor_reg;
                                            job.lit_cnt  = rem;
                                            job.lit_wb   = 1'b1;
                                            job.tail_en  = 1'b1;
                                            job.move_cnt = rem + 5'd1;
                                        end
                                        cursor_next = cursor_reg - 5'd1;
                                        length_next = length_reg - 5'd1;
                                    end
                                end else if (s_key == KEY_FF) begin
                                    // clear screen, redraw, put the cursor back
                                    start         = 1'b1;
                                    job.head_en   = 1'b1;
                                    job.head_kind = TOK_CLEAR;
                                    job.lit_lo    = '0;
                                    job.lit_cnt   = length_reg;
                                    job.move_cnt  = rem;
                                end else if (s_key == KEY_ESC) begin
                                    escape_next = ESC_SEEN;
                                end else if (s_key == KEY_LF) begin
                                    start          = 1'b1;
                                    job.move_kind  = TOK_RIGHT;
                                    job.move_cnt   = rem;
                                    job.final_en   = 1'b1;
                                    job.final_byte = KEY_LF;
                                    cursor_next    = length_reg;
                                    finished_next  = 1'b1;
                                end else begin
                                    // insert: shift tail up, echo from cursor, step back
                                    start         = 1'b1;
                                    job.shift_en  = 1'b1;
                                    job.shift_hi  = length_reg;
                                    job.shift_lo  = cursor_reg;
                                    job.ins_byte  = s_key;
                                    job.lit_lo    = cursor_reg;
                                    job.lit_cnt   = rem + 5'd1;
                                    job.move_cnt  = rem;
                                    length_next   = length_reg + 5'd1;
                                    cursor_next   = cursor_reg + 5'd1;
                                end
                            end
                            if (length_next >= limit) begin
                                finished_next = 1'b1;
                            end
                        end
                    end
                end
                FUNC_NEW: begin
                    length_next   = '0;
                    cursor_next   = '0;
                    escape_next   = ESC_NONE;
                    finished_next = (limit == '0);
                end
                FUNC_READ: begin
                    // out-of-range index reads as zero
                    start         = 1'b1;
                    job.lit_kind  = TOK_READ;
                    job.lit_cnt   = 5'd1;
                    job.read_zero = !(ridx_ext < DEPTH_L);
                    job.lit_lo    = (ridx_ext < DEPTH_L) ? ridx_ext : '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= 5'd16;
            length_reg   <= '0;
            cursor_reg   <= '0;
            escape_reg   <= ESC_NONE;
            finished_reg <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
            length_reg   <= length_next;
            cursor_reg   <= cursor_next;
            escape_reg   <= escape_next;
            finished_reg <= finished_next;
        end
    end

    tle_seq #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .job          (job),
        .done_in      (finished_reg),
        .len_in       (length_reg),
        .busy         (busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_kind (m_token_kind),
        .m_token_byte (m_token_byte),
        .m_last       (m_last),
        .m_line_done  (m_line_done),
        .m_line_length(m_line_length),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    tle_line_mem #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

`ifndef SYNTH
    // cursor stays inside the line
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= length_reg)
        else $error("cursor beyond line end");

    // line never outgrows the store
    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= DEPTH_L)
        else $error("line length beyond store depth");

    // only literal and read tokens carry a byte
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_token_kind != TOK_LIT && m_token_kind != TOK_READ)
            |-> (m_token_byte == 8'd0))
        else $error("control token carries a byte");

    // no new request while tokens are still being produced
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && start) |=> !s_ready)
        else $error("request accepted during token run");
`endif

endmodule

>>> verif/terminal_line_editor_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// terminal_line_editor_checker
// Watches the request, token and register channels, predicts the token
// stream of every accepted request and compares it field by field.
// ---------------------------------------------------------------------------
module terminal_line_editor_checker import tle_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_key,
    input  logic [3:0]        s_read_index,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [KIND_W-1:0] m_token_kind,
    input  logic [7:0]        m_token_byte,
    input  logic              m_last,
    input  logic              m_line_done,
    input  logic [LEN_W-1:0]  m_line_length,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    output int                fail_count,
    output int                tokens_pending
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        tbyte;
        logic              last;
        logic              done;
        logic [LEN_W-1:0]  len;
    } token_t;

    token_t     token_q[$];
    token_t     run[$];
    logic [7:0] shadow_line[TLE_LINE_DEPTH];
    int         line_len, cur, esc, fin, max_len;

    assign tokens_pending = token_q.size();

    function automatic int line_limit();
        return (max_len > TLE_LINE_DEPTH) ? TLE_LINE_DEPTH : max_len;
    endfunction

    function automatic void push_tok(logic [KIND_W-1:0] k, logic [7:0] b);
        token_t t;
        t = '0;
        t.kind = k;
        t.tbyte = b;
        run.push_back(t);
    endfunction

    function automatic void edit_key(logic [7:0] ch);
        int rem;
        if (esc == 1) begin
            esc = (ch == KEY_BRACKET) ? 2 : 0;
            return;
        end
        if (esc == 2) begin
            if (ch == KEY_LEFT && cur > 0) begin
                push_tok(TOK_LEFT, 8'd0);
                cur--;
            end else if (ch == KEY_RIGHT && cur < line_len) begin
                push_tok(TOK_RIGHT, 8'd0);
                cur++;
            end
            esc = 0;
            return;
        end
        esc = 0;
        if (ch == KEY_BS) begin
            if (line_len == 0 || cur == 0) return;
            push_tok(TOK_ERASE, 8'd0);
            if (cur != line_len) begin
                rem = line_len - cur;
                for (int i = 0; i < rem; i++) begin
                    push_tok(TOK_LIT, shadow_line[cur + i]);
                    shadow_line[cur + i - 1] = shadow_line[cur + i];
                end
                push_tok(TOK_LIT, BYTE_SPACE);
                for (int i = 0; i < rem + 1; i++) push_tok(TOK_LEFT, 8'd0);
            end
            cur--;
            line_len--;
        end else if (ch == KEY_FF) begin
            push_tok(TOK_CLEAR, 8'd0);
            for (int i = 0; i < line_len; i++) push_tok(TOK_LIT, shadow_line[i]);
            for (int i = cur; i < line_len; i++) push_tok(TOK_LEFT, 8'd0);
        end else if (ch == KEY_ESC) begin
            esc = 1;
        end else if (ch == KEY_LF) begin
            while (cur < line_len) begin
                push_tok(TOK_RIGHT, 8'd0);
                cur++;
            end
            push_tok(TOK_LIT, KEY_LF);
            fin = 1;
        end else if (cur != line_len) begin
            for (int i = line_len; i > cur; i--) shadow_line[i] = shadow_line[i - 1];
            shadow_line[cur] = ch;
            line_len++;
            cur++;
            for (int i = cur - 1; i < line_len; i++) push_tok(TOK_LIT, shadow_line[i]);
            for (int i = cur; i < line_len; i++) push_tok(TOK_LEFT, 8'd0);
        end else begin
            push_tok(TOK_LIT, ch);
            shadow_line[line_len] = ch;
            line_len++;
            cur++;
        end
    endfunction

    // predict one request, then stamp the trailing fields on its tokens
    function automatic void predict_request(logic [1:0] f, logic [7:0] k, logic [3:0] ri);
        token_t t;
        run.delete();
        if (f == FUNC_KEY) begin
            if (!fin) begin
                if (line_len >= line_limit()) fin = 1;
                else begin
                    edit_key(k);
                    if (line_len >= line_limit()) fin = 1;
                end
            end
        end else if (f == FUNC_NEW) begin
            line_len = 0;
            cur = 0;
            esc = 0;
            fin = (line_limit() == 0) ? 1 : 0;
        end else if (f == FUNC_READ) begin
            push_tok(TOK_READ, shadow_line[ri]);
        end
        foreach (run[i]) begin
            t = run[i];
            t.last = (i == run.size() - 1);
            t.done = fin[0];
            t.len = line_len[LEN_W-1:0];
            token_q.push_back(t);
        end
    endfunction

    always @(posedge aclk) begin
        token_t exp_t, got;
        if (!aresetn) begin
            line_len = 0;
            cur = 0;
            esc = 0;
            fin = 1;
            max_len = 16;
            token_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) max_len = int'(cfg_data);
            if (s_valid && s_ready) predict_request(s_func, s_key, s_read_index);
            if (m_valid && m_ready) begin
                got = '{m_token_kind, m_token_byte, m_last, m_line_done, m_line_length};
                if (token_q.size() == 0) begin
                    $display("%0t: token with none expected, actual %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_t = token_q.pop_front();
                    if (got !== exp_t) begin
                        $display("%0t: token mismatch, expected %p actual %p",
                                 $time, exp_t, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/terminal_line_editor_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// terminal_line_editor_tb
// Drives edit, new-line and read requests plus max_length writes into the
// line editor under random stalls; the checker scores the token stream.
// ---------------------------------------------------------------------------
module terminal_line_editor_tb;
    import tle_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_func;
    logic [7:0]        s_key;
    logic [3:0]        s_read_index;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KIND_W-1:0] m_token_kind;
    logic [7:0]        m_token_byte;
    logic              m_last;
    logic              m_line_done;
    logic [LEN_W-1:0]  m_line_length;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data;
    int                fail_count;
    int                tokens_pending;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    int                cycle_count = 0;
    // stored positions written since reset, so reads never touch a blank entry
    int                written_depth = 0;

    terminal_line_editor dut (.*);

    terminal_line_editor_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver stall pattern, changes at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** terminal_line_editor: FAILED **");
            $finish;
        end
    end

    // track the reachable store depth from what the editor reports
    always @(posedge aclk) begin
        if (m_valid && m_ready && int'(m_line_length) > written_depth)
            written_depth <= int'(m_line_length);
    end

    // one request, held until accepted; random gap before it
    // valid stays high on return so a following request can start at once
    task automatic send_request(input logic [1:0] f, input logic [7:0] k, input logic [3:0] ri);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_key <= k;
        s_read_index <= ri;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_key(input logic [7:0] k);
        send_request(FUNC_KEY, k, 4'd0);
    endtask

    // read a position already written, or one beyond depth never (4-bit index)
    task automatic send_read();
        logic [3:0] ri;
        if (written_depth == 0) ri = 4'd0;
        else ri = 4'($urandom_range(written_depth - 1));
        if (written_depth > 0) send_request(FUNC_READ, 8'd0, ri);
    endtask

    // quiet the block, then write max_length
    task automatic write_limit(input logic [LEN_W-1:0] v);
        s_valid <= 1'b0;
        while (tokens_pending != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == KEY_BS || c == KEY_LF || c == KEY_FF || c == KEY_ESC) c = 8'h41;
        return c;
    endfunction

    // a plausible editing session: fill, move, delete, redraw, finish
    task automatic edit_session();
        int n;
        send_request(FUNC_NEW, 8'd0, 4'd0);
        n = $urandom_range(14);
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_key(random_char());
                4: begin
                    send_key(KEY_ESC);
                    send_key(KEY_BRACKET);
                    send_key(KEY_LEFT);
                end
                5: begin
                    send_key(KEY_ESC);
                    send_key(KEY_BRACKET);
                    send_key(KEY_RIGHT);
                end
                6: send_key(KEY_BS);
                7: send_key(KEY_FF);
                8: send_read();
                default: begin
                    // noise and broken sequences
                    if ($urandom_range(1)) send_key(KEY_ESC);
                    send_key(8'($urandom_range(255)));
                    if ($urandom_range(3) == 0)
                        send_request(2'd3, 8'($urandom_range(255)), 4'($urandom_range(15)));
                end
            endcase
        end
        if ($urandom_range(2) != 0) send_key(KEY_LF);
    endtask

    // a session averages about thirteen requests
    task automatic run_phase(input int items);
        repeat (items / 13) edit_session();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_KEY;
        s_key = 8'd0;
        s_read_index = 4'd0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: keys while finished, then a line with edits and extremes
        send_key(8'h61);
        send_request(FUNC_NEW, 8'd0, 4'd0);
        send_key(8'h00);
        send_key(8'hff);
        send_key(8'h09);
        send_key(KEY_ESC);
        send_key(KEY_BRACKET);
        send_key(KEY_LEFT);
        send_key(8'h7a);
        send_key(KEY_BS);
        send_key(KEY_FF);
        send_key(KEY_ESC);
        send_key(KEY_BRACKET);
        send_key(8'd65);
        send_request(FUNC_READ, 8'd0, 4'd1);
        send_request(2'd3, 8'hff, 4'hf);
        send_key(KEY_LF);
        send_key(8'h62);
        send_request(FUNC_NEW, 8'd0, 4'd0);
        send_key(KEY_BS);

        // fill to the largest limit, then past it
        write_limit(5'd31);
        send_request(FUNC_NEW, 8'd0, 4'd0);
        repeat (17) send_key(random_char());
        send_request(FUNC_READ, 8'd0, 4'd15);
        write_limit(5'd0);
        send_request(FUNC_NEW, 8'd0, 4'd0);
        send_key(8'h61);
        write_limit(5'd1);
        send_request(FUNC_NEW, 8'd0, 4'd0);
        send_key(8'h61);

        sender_idle_pct = 23;
        receiver_idle_pct = 51;
        write_limit(5'd16);
        run_phase(120);
        sender_idle_pct = 51;
        receiver_idle_pct = 23;
        write_limit(5'($urandom_range(2, 15)));
        run_phase(120);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_limit(5'd8);
        run_phase(130);

        s_valid <= 1'b0;
        while (tokens_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) begin
            $display("** terminal_line_editor: PASSED **");
        end else begin
            $display("** terminal_line_editor: FAILED **");
        end
        $finish;
    end

endmodule
